// ----- src/vm_alu_with_nz_flags_core_macros.svh -----
// Assertion macros used by the checker file of the execute unit.
`ifndef VM_ALU_WITH_NZ_FLAGS_CORE_MACROS_SVH
`define VM_ALU_WITH_NZ_FLAGS_CORE_MACROS_SVH

// Check a property while reset is released.
`define VMALU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property at every edge, reset included.
`define VMALU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- src/vmalu_pkg.sv -----
// Types and constants shared by the execute unit modules.
`default_nettype none

package vmalu_pkg;

  localparam int DataW     = 32;
  localparam int HalfW     = DataW / 2;
  localparam int FuncW     = 5;
  localparam int StepCntW  = $clog2(DataW);
  localparam int InFieldsW = FuncW + 2 * DataW;
  localparam int TdataInW  = ((InFieldsW + 7) / 8) * 8;
  localparam int TdataOutW = 2 * DataW;
  localparam int TuserW    = 8;

  typedef enum logic [FuncW-1:0] {
    FN_MOV  = 5'd0,
    FN_ADD  = 5'd1,
    FN_SUB  = 5'd2,
    FN_MUL  = 5'd3,
    FN_DIV  = 5'd4,
    FN_CMP  = 5'd5,
    FN_SHL  = 5'd6,
    FN_SHR  = 5'd7,
    FN_SAR  = 5'd8,
    FN_AND  = 5'd9,
    FN_OR   = 5'd10,
    FN_XOR  = 5'd11,
    FN_SWAP = 5'd12,
    FN_LDL  = 5'd13,
    FN_LDH  = 5'd14,
    FN_JMP  = 5'd15,
    FN_JZ   = 5'd16,
    FN_JNZ  = 5'd17,
    FN_JN   = 5'd18,
    FN_JNN  = 5'd19,
    FN_JP   = 5'd20,
    FN_JNP  = 5'd21,
    FN_NOT  = 5'd22,
    FN_STOP = 5'd23
  } vmalu_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MDWAIT,
    ST_MDFIN
  } vmalu_state_e;

  // Request into the iterative multiply/divide unit.
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
  } vmalu_md_req_t;

  // Response: quot carries the product for a multiply.
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } vmalu_md_rsp_t;

endpackage

`default_nettype wire

// ----- src/vmalu_muldiv.sv -----
// Iterative multiply and signed divide sharing one add/subtract unit.
`default_nettype none

module vmalu_muldiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vmalu_pkg::vmalu_md_req_t req_i,
  output vmalu_pkg::vmalu_md_rsp_t rsp_o
);
  import vmalu_pkg::*;

  localparam int AddW = DataW + 2;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                is_div_q;
  logic                neg_quo_q;
  logic                neg_rem_q;
  logic [DataW-1:0]    acc_q;
  logic [DataW-1:0]    sh_q;
  logic [DataW-1:0]    mc_q;

  logic [DataW-1:0]    a_mag;
  logic [DataW-1:0]    b_mag;
  logic [AddW-1:0]     add_x;
  logic [AddW-1:0]     add_y;
  logic                add_sub;
  logic [AddW-1:0]     add_sum;

  assign a_mag = req_i.op_a[DataW-1] ? (DataW'(0) - req_i.op_a) : req_i.op_a;
  assign b_mag = req_i.op_b[DataW-1] ? (DataW'(0) - req_i.op_b) : req_i.op_b;

  // Shared adder: trial subtract for divide, conditional add for multiply.
  always_comb begin
    if (is_div_q) begin
      add_x   = {1'b0, acc_q, sh_q[DataW-1]};
      add_y   = {2'b00, mc_q};
      add_sub = 1'b1;
    end else begin
      add_x   = {2'b00, acc_q};
      add_y   = sh_q[0] ? {2'b00, mc_q} : '0;
      add_sub = 1'b0;
    end
  end

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(AddW-1){1'b0}}, add_sub};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = StepCntW'(DataW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - StepCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      is_div_q  <= req_i.is_div;
      acc_q     <= '0;
      neg_quo_q <= req_i.op_a[DataW-1] ^ req_i.op_b[DataW-1];
      neg_rem_q <= req_i.op_a[DataW-1];
      if (req_i.is_div) begin
        sh_q <= a_mag;
        mc_q <= b_mag;
      end else begin
        sh_q <= req_i.op_b;
        mc_q <= req_i.op_a;
      end
    end else if (busy_q) begin
      if (is_div_q) begin
        // Keep the shifted remainder when the trial subtract borrows.
        acc_q <= add_sum[AddW-1] ? add_x[DataW-1:0] : add_sum[DataW-1:0];
        sh_q  <= {sh_q[DataW-2:0], ~add_sum[AddW-1]};
      end else begin
        acc_q <= add_sum[DataW-1:0];
        sh_q  <= {1'b0, sh_q[DataW-1:1]};
        mc_q  <= {mc_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (is_div_q) begin
      rsp_o.quot = neg_quo_q ? (DataW'(0) - sh_q) : sh_q;
    end else begin
      rsp_o.quot = acc_q;
    end
    rsp_o.rem = neg_rem_q ? (DataW'(0) - acc_q) : acc_q;
  end

endmodule

`default_nettype wire

// ----- src/vm_alu_with_nz_flags_core.sv -----
// MUL and DIV with a nonzero divisor go from the input transaction in ST_IDLE through ST_EXEC
//   (start), ST_MDWAIT (32 steps of the shared add/subtract unit, then the done handoff) and
//   ST_MDFIN (writeback) back to ST_IDLE; every other operation is written back from ST_EXEC.
//   A new item is taken only in ST_IDLE, after the previous one has been written back;
//   a result still held by the receiver stalls the next writeback.
// Reset: rst_ni clears the sequencer, the output valid flag and the N/Z flags.
`default_nettype none

module vm_alu_with_nz_flags_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // func [4:0], op_a [36:5], op_b [68:37], zero fill [71:69]
  input  logic [vmalu_pkg::TdataInW-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // result [31:0], second_value [63:32]
  output logic [vmalu_pkg::TdataOutW-1:0] m_axis_tdata_o,
  // write_dest [0], write_second [1], write_acc [2], set_ip [3], halt [4],
  // div_by_zero [5], flag_n [6], flag_z [7]
  output logic [vmalu_pkg::TuserW-1:0]   m_axis_tuser_o
);
  import vmalu_pkg::*;

  vmalu_state_e     state_q, state_d;
  logic [FuncW-1:0] func_q;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic             nf_q, zf_q;

  logic                 out_valid_q;
  logic [TdataOutW-1:0] out_data_q;
  logic [TuserW-1:0]    out_user_q;

  vmalu_md_req_t md_req;
  vmalu_md_rsp_t md_rsp;

  logic             in_accept;
  logic             slot_free;
  logic             muldiv_op;
  logic             load;

  logic [DataW-1:0] sum_res;
  logic [DataW-1:0] diff_res;
  logic             sh_big;
  logic [StepCntW-1:0] shamt;

  logic [DataW-1:0] res, sec, flag_src;
  logic             wd, ws, wa, sip, hlt, dz, upd, take;
  logic             n_new, z_new;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign muldiv_op = (func_q == FN_MUL) || ((func_q == FN_DIV) && (b_q != '0));

  assign sum_res  = a_q + b_q;
  assign diff_res = a_q - b_q;
  assign sh_big   = |b_q[DataW-1:StepCntW];
  assign shamt    = b_q[StepCntW-1:0];

  vmalu_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (muldiv_op) state_d = ST_MDWAIT;
        else if (slot_free) state_d = ST_IDLE;
      end
      ST_MDWAIT: begin
        if (md_rsp.done) state_d = ST_MDFIN;
      end
      ST_MDFIN: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    md_req.start    = 1'b0;
    load            = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_EXEC: begin
        md_req.start = muldiv_op;
        load         = !muldiv_op && slot_free;
      end
      ST_MDWAIT: load = 1'b0;
      ST_MDFIN:  load = slot_free;
      default:   load = 1'b0;
    endcase
  end

  assign md_req.is_div = (func_q == FN_DIV);
  assign md_req.op_a   = a_q;
  assign md_req.op_b   = b_q;

  // Operation decode
  always_comb begin
    res      = '0;
    sec      = '0;
    wd       = 1'b0;
    ws       = 1'b0;
    wa       = 1'b0;
    sip      = 1'b0;
    hlt      = 1'b0;
    dz       = 1'b0;
    upd      = 1'b0;
    take     = 1'b0;
    flag_src = '0;
    case (func_q)
      FN_MOV: begin
        res = b_q;
        wd  = 1'b1;
      end
      FN_ADD: begin
        res = sum_res;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_SUB: begin
        res = diff_res;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_MUL: begin
        res = md_rsp.quot;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_DIV: begin
        if (b_q == '0) begin
          dz = 1'b1;
        end else begin
          res = md_rsp.quot;
          sec = md_rsp.rem;
          wd  = 1'b1;
          wa  = 1'b1;
          upd = 1'b1;
        end
      end
      FN_CMP: upd = 1'b1;
      FN_SHL: begin
        res = sh_big ? '0 : (a_q << shamt);
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_SHR: begin
        res = sh_big ? '0 : (a_q >> shamt);
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_SAR: begin
        res = sh_big ? {DataW{a_q[DataW-1]}} : DataW'($signed(a_q) >>> shamt);
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_AND: begin
        res = a_q & b_q;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_OR: begin
        res = a_q | b_q;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_XOR: begin
        res = a_q ^ b_q;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_SWAP: begin
        res = b_q;
        sec = a_q;
        wd  = 1'b1;
        ws  = 1'b1;
      end
      FN_LDL: begin
        res = {a_q[DataW-1:HalfW], b_q[HalfW-1:0]};
        wd  = 1'b1;
      end
      FN_LDH: begin
        res = {b_q[HalfW-1:0], a_q[HalfW-1:0]};
        wd  = 1'b1;
      end
      FN_JMP: take = 1'b1;
      FN_JZ:  take = zf_q && !nf_q;
      FN_JNZ: take = !zf_q;
      FN_JN:  take = nf_q && !zf_q;
      FN_JNN: take = !nf_q;
      FN_JP:  take = !zf_q && !nf_q;
      FN_JNP: take = zf_q ^ nf_q;
      FN_NOT: begin
        res = ~a_q;
        wd  = 1'b1;
        upd = 1'b1;
      end
      FN_STOP: begin
        res = '1;
        sip = 1'b1;
        hlt = 1'b1;
      end
      default: res = '0;
    endcase

    if (take) begin
      res = a_q;
      sip = 1'b1;
    end

    // CMP sets flags from the difference but writes nothing.
    flag_src = (func_q == FN_CMP) ? diff_res : res;
  end

  assign n_new = upd ? flag_src[DataW-1] : nf_q;
  assign z_new = upd ? (flag_src == '0) : zf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nf_q        <= 1'b0;
      zf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        nf_q        <= n_new;
        zf_q        <= z_new;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= s_axis_tdata_i[FuncW-1:0];
      a_q    <= s_axis_tdata_i[FuncW +: DataW];
      b_q    <= s_axis_tdata_i[FuncW+DataW +: DataW];
    end
    if (load) begin
      out_data_q <= {sec, res};
      out_user_q <= {z_new, n_new, dz, hlt, sip, wa, ws, wd};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

// ----- src/vmalu_checker.sv -----
// Port-level checker for the execute unit, bound to the top level.
`default_nettype none

`include "vm_alu_with_nz_flags_core_macros.svh"

module vmalu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_i,
  input logic                            m_axis_tvalid_i,
  // result [31:0], second_value [63:32]
  input logic [vmalu_pkg::TdataOutW-1:0] m_axis_tdata_i,
  // write_dest, write_second, write_acc, set_ip, halt, div_by_zero, flag_n, flag_z
  input logic [vmalu_pkg::TuserW-1:0]    m_axis_tuser_i
);
  import vmalu_pkg::*;

  logic             in_fire;
  logic             halt_seen;
  logic             dz_seen;
  logic [DataW-1:0] out_result;
  logic [3:0]       out_wr;
  logic             out_ws;
  logic             out_wa;
  logic             out_sip;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_i;
  assign halt_seen  = m_axis_tvalid_i && m_axis_tuser_i[4];
  assign dz_seen    = m_axis_tvalid_i && m_axis_tuser_i[5];
  assign out_result = m_axis_tdata_i[DataW-1:0];
  assign out_wr     = m_axis_tuser_i[3:0];
  assign out_ws     = m_axis_tuser_i[1];
  assign out_wa     = m_axis_tuser_i[2];
  assign out_sip    = m_axis_tuser_i[3];

  // Hold off new work in the cycle after a transaction.
  `VMALU_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !s_axis_tready_i)

  // STOP loads -1 into the instruction pointer.
  `VMALU_ASSERT(a_halt_sets_ip, clk_i, rst_ni, halt_seen |-> (out_sip && (out_result == '1)))

  // Division by zero writes nothing.
  `VMALU_ASSERT(a_dz_no_write, clk_i, rst_ni, dz_seen |-> ((out_wr == '0) && (m_axis_tdata_i == '0)))

  // Swap and divide never write both second targets.
  `VMALU_ASSERT(a_one_second_target, clk_i, rst_ni, m_axis_tvalid_i |-> !(out_ws && out_wa))

  // No output right after an edge with reset held.
  `VMALU_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_i)

endmodule

bind vm_alu_with_nz_flags_core vmalu_checker u_vmalu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the execute unit with N/Z condition flags.
module tb;
  import vmalu_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 7;
  localparam int TimeoutCycles = 400000;
  localparam int SettleCycles  = 40;
  localparam int IdlePct       = 36;

  localparam logic [FuncW-1:0] UnusedFuncLo = FuncW'(FN_STOP + 1);
  localparam logic [FuncW-1:0] UnusedFuncHi = '1;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             write_dest;
    logic [DataW-1:0] second_value;
    logic             write_second;
    logic             write_acc;
    logic             set_ip;
    logic             halt;
    logic             div_by_zero;
    logic             flag_n;
    logic             flag_z;
  } exec_out_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // func [4:0], op_a [36:5], op_b [68:37], zero fill [71:69]
  logic [TdataInW-1:0]  s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // result [31:0], second_value [63:32]
  logic [TdataOutW-1:0] m_axis_tdata_o;
  // write_dest [0], write_second [1], write_acc [2], set_ip [3], halt [4],
  // div_by_zero [5], flag_n [6], flag_z [7]
  logic [TuserW-1:0]    m_axis_tuser_o;

  exec_out_t pending_q[$];
  logic      kept_neg  = 1'b0;
  logic      kept_zero = 1'b0;
  int        mismatch_cnt = 0;
  bit        tx_idle_on   = 1'b1;
  bit        rx_idle_on   = 1'b1;
  int        rx_hold_left = 0;

  vm_alu_with_nz_flags_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Compute the result of one operation and advance the kept flags.
  function automatic exec_out_t execute_op(input logic [FuncW-1:0] fn,
                                           input logic [DataW-1:0] a,
                                           input logic [DataW-1:0] b);
    exec_out_t  o;
    logic       take;
    logic       upd;
    logic [DataW-1:0] nz_src;
    longint     quo;
    longint     rem;
    o      = '0;
    take   = 1'b0;
    upd    = 1'b0;
    nz_src = '0;
    case (fn)
      FN_MOV: begin
        o.result = b; o.write_dest = 1'b1;
      end
      FN_ADD: begin
        o.result = a + b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_SUB: begin
        o.result = a - b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_MUL: begin
        o.result = a * b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_DIV: begin
        if (b == '0) begin
          o.div_by_zero = 1'b1;
        end else begin
          // widen so that minimum over minus one cannot overflow
          quo = longint'($signed(a)) / longint'($signed(b));
          rem = longint'($signed(a)) % longint'($signed(b));
          o.result       = DataW'(quo);
          o.second_value = DataW'(rem);
          o.write_dest   = 1'b1;
          o.write_acc    = 1'b1;
          upd            = 1'b1;
        end
      end
      FN_CMP: begin
        nz_src = a - b; upd = 1'b1;
      end
      FN_SHL: begin
        o.result = (b < DataW) ? a << b[StepCntW-1:0] : '0;
        o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_SHR: begin
        o.result = (b < DataW) ? a >> b[StepCntW-1:0] : '0;
        o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_SAR: begin
        o.result = (b < DataW) ? DataW'($signed(a) >>> b[StepCntW-1:0]) : {DataW{a[DataW-1]}};
        o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_AND: begin
        o.result = a & b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_OR: begin
        o.result = a | b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_XOR: begin
        o.result = a ^ b; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_SWAP: begin
        o.result = b; o.second_value = a;
        o.write_dest = 1'b1; o.write_second = 1'b1;
      end
      FN_LDL: begin
        o.result = {a[DataW-1:HalfW], b[HalfW-1:0]}; o.write_dest = 1'b1;
      end
      FN_LDH: begin
        o.result = {b[HalfW-1:0], a[HalfW-1:0]}; o.write_dest = 1'b1;
      end
      FN_JMP: take = 1'b1;
      FN_JZ:  take = kept_zero && !kept_neg;
      FN_JNZ: take = !kept_zero;
      FN_JN:  take = kept_neg && !kept_zero;
      FN_JNN: take = !kept_neg;
      FN_JP:  take = !kept_zero && !kept_neg;
      FN_JNP: take = kept_zero != kept_neg;
      FN_NOT: begin
        o.result = ~a; o.write_dest = 1'b1; upd = 1'b1;
      end
      FN_STOP: begin
        o.result = '1; o.set_ip = 1'b1; o.halt = 1'b1;
      end
      default: ;
    endcase
    if (take) begin
      o.result = a;
      o.set_ip = 1'b1;
    end
    if (upd) begin
      if (fn != FN_CMP) nz_src = o.result;
      kept_neg  = nz_src[DataW-1];
      kept_zero = (nz_src == '0);
    end
    o.flag_n = kept_neg;
    o.flag_z = kept_zero;
    return o;
  endfunction

  function automatic void check_field(input string fname,
                                      input logic [DataW-1:0] want,
                                      input logic [DataW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Compare each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    exec_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatch_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("result",       want.result,       m_axis_tdata_o[DataW-1:0]);
        check_field("second_value", want.second_value, m_axis_tdata_o[2*DataW-1:DataW]);
        check_field("write_dest",   want.write_dest,   m_axis_tuser_o[0]);
        check_field("write_second", want.write_second, m_axis_tuser_o[1]);
        check_field("write_acc",    want.write_acc,    m_axis_tuser_o[2]);
        check_field("set_ip",       want.set_ip,       m_axis_tuser_o[3]);
        check_field("halt",         want.halt,         m_axis_tuser_o[4]);
        check_field("div_by_zero",  want.div_by_zero,  m_axis_tuser_o[5]);
        check_field("flag_n",       want.flag_n,       m_axis_tuser_o[6]);
        check_field("flag_z",       want.flag_z,       m_axis_tuser_o[7]);
      end
    end
  end

  // Result receiver: random stalls, always ready with stalls off, or a counted hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_idle_on) begin
        m_axis_tready_i <= ($urandom_range(99) >= IdlePct);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Offer one operation and hold it until the block takes it.
  task automatic issue_op(input logic [FuncW-1:0] fn,
                          input logic [DataW-1:0] a,
                          input logic [DataW-1:0] b);
    while (tx_idle_on && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TdataInW'({b, a, fn});
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q.push_back(execute_op(fn, a, b));
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return DataW'(1);
      2: return '1;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return DataW'($urandom_range(40));
      6: return DataW'(-int'($urandom_range(40)));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FuncW-1:0] rand_func();
    if ($urandom_range(99) < 3) return FuncW'($urandom_range(UnusedFuncHi, UnusedFuncLo));
    return FuncW'($urandom_range(FN_STOP, FN_MOV));
  endfunction

  task automatic random_op();
    logic [FuncW-1:0] fn;
    logic [DataW-1:0] b;
    fn = rand_func();
    b  = rand_word();
    if ((fn == FN_SHL || fn == FN_SHR || fn == FN_SAR) && $urandom_range(1))
      b = DataW'($urandom_range(40));
    if (fn == FN_DIV && $urandom_range(19) == 0)
      b = '0;
    issue_op(fn, rand_word(), b);
  endtask

  task automatic test_directed_cases();
    issue_op(FN_MOV,  32'h0000_0000, 32'h8000_0000);
    issue_op(FN_ADD,  32'h7FFF_FFFF, 32'h0000_0001);
    issue_op(FN_JN,   32'h0000_0100, 32'h0000_0000);
    issue_op(FN_JNP,  32'h0000_0104, 32'h0000_0000);
    issue_op(FN_SUB,  32'h0000_0005, 32'h0000_0005);
    issue_op(FN_JZ,   32'h0000_0108, 32'h0000_0000);
    issue_op(FN_JNZ,  32'h0000_010C, 32'h0000_0000);
    issue_op(FN_MUL,  32'hFFFF_FFFF, 32'h7FFF_FFFF);
    issue_op(FN_DIV,  32'hFFFF_FFF9, 32'h0000_0002);
    issue_op(FN_DIV,  32'h8000_0000, 32'hFFFF_FFFF);
    issue_op(FN_DIV,  32'h0000_0009, 32'h0000_0000);
    issue_op(FN_CMP,  32'h0000_0001, 32'h0000_0002);
    issue_op(FN_SHL,  32'h0000_0001, 32'd31);
    issue_op(FN_SHL,  32'h0000_0001, 32'd32);
    issue_op(FN_SHR,  32'h8000_0000, 32'd31);
    issue_op(FN_SAR,  32'h8000_0000, 32'hFFFF_FFFF);
    issue_op(FN_SAR,  32'h4000_0000, 32'd40);
    issue_op(FN_AND,  32'hFFFF_0000, 32'h0000_FFFF);
    issue_op(FN_OR,   32'hFFFF_0000, 32'h0000_FFFF);
    issue_op(FN_XOR,  32'hFFFF_FFFF, 32'h0000_FFFF);
    issue_op(FN_SWAP, 32'h1234_5678, 32'h8765_4321);
    issue_op(FN_LDL,  32'h1234_5678, 32'hABCD_EF01);
    issue_op(FN_LDH,  32'h1234_5678, 32'hABCD_EF01);
    issue_op(FN_NOT,  32'h0000_0000, 32'h0000_0000);
    issue_op(FN_JMP,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_op(FN_STOP, 32'h0000_0000, 32'h0000_0000);
    issue_op(UnusedFuncLo, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(UnusedFuncHi, 32'h8000_0000, 32'h0000_0001);
    drain_results();
  endtask

  task automatic test_random_ops();
    repeat (320) random_op();
    drain_results();
  endtask

  // Stall the result side long enough for the block to back up its input.
  task automatic test_result_backpressure();
    tx_idle_on   = 1'b0;
    rx_hold_left = 150;
    repeat (30) random_op();
    tx_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_streaming_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (80) random_op();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_ops();
    test_result_backpressure();
    test_streaming_no_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("vm_alu_with_nz_flags_core: match");
    end else begin
      $display("vm_alu_with_nz_flags_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("vm_alu_with_nz_flags_core: mismatch");
    $finish;
  end

endmodule

// ----- vm_alu_with_nz_flags_core.f -----
+incdir+src
src/vmalu_pkg.sv
src/vmalu_muldiv.sv
src/vm_alu_with_nz_flags_core.sv
src/vmalu_checker.sv
tb/sv/tb.sv
